// ===== hw/rtl/ctrl_a_code_to_ansi_translator_unit_assert.svh =====
// Assertion macros for the Ctrl-A translator.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CTRL_A_CODE_TO_ANSI_TRANSLATOR_UNIT_ASSERT_SVH
`define CTRL_A_CODE_TO_ANSI_TRANSLATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CATA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CATA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cata_pkg.sv =====
// Shared types and constants for the Ctrl-A to ANSI translator.
// No dependencies.
package cata_pkg;

    localparam int MAX_RUN  = 6;
    localparam int LEN_W    = 3;
    localparam int Q_DEPTH  = 4;

    localparam logic [7:0] C_PREFIX = 8'h01;
    localparam logic [7:0] C_ESC    = 8'h1B;
    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_HIGH   = 8'h7F;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_CASE   = 8'h20;

    // One run of output bytes; bytes[0] goes out first.
    typedef struct packed {
        logic [LEN_W-1:0]              len;
        logic [MAX_RUN-1:0][7:0]       bytes;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/cata_if.sv =====
// Valid/ready stream interfaces for the translator's input and output.
// No dependencies.
interface cata_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cata_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/cata_front.sv =====
// Front end: accepts input bytes, tracks the prefix flag, builds output runs.
// Depends on cata_pkg and cata_if.
module cata_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cata_in_if.sink             i_in,
    input  cata_pkg::t_q_stat   i_q_stat,
    output cata_pkg::t_push     o_push,
    output logic                o_prefix_pending
);

    logic                r_prefix;
    logic                n_prefix;
    logic                w_accept;
    logic [7:0]          w_raw;
    logic [7:0]          w_up;
    logic [7:0]          w_cnt;
    logic [6:0]          w_rem;
    logic [14:0]         w_prod;
    logic [3:0]          w_tens;
    logic [3:0]          w_ones;
    cata_pkg::t_desc     w_code;
    cata_pkg::t_desc     w_desc;

    function automatic logic [2:0] fg_digit(input logic [7:0] c);
        logic [2:0] d;
        d = 3'd0;
        case (c)
            "K":     d = 3'd0;
            "R":     d = 3'd1;
            "G":     d = 3'd2;
            "Y":     d = 3'd3;
            "B":     d = 3'd4;
            "M":     d = 3'd5;
            "C":     d = 3'd6;
            "W":     d = 3'd7;
            default: d = 3'd0;
        endcase
        return d;
    endfunction

    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_raw      = i_in.in_byte;
    assign w_up       = (w_raw >= "a" && w_raw <= "z") ? w_raw - cata_pkg::C_CASE : w_raw;

    // Decimal split of the cursor count (0..128); rem*205>>11 is rem/10 for rem < 100.
    assign w_cnt  = w_raw - cata_pkg::C_HIGH;
    assign w_rem  = (w_cnt >= 8'd100) ? 7'(w_cnt - 8'd100) : w_cnt[6:0];
    assign w_prod = 15'(w_rem) * 15'd205;
    assign w_tens = w_prod[14:11];
    assign w_ones = 4'(w_rem - 7'(w_tens) * 7'd10);

    always_comb begin
        w_code       = '0;
        w_code.bytes[0] = cata_pkg::C_ESC;
        w_code.bytes[1] = "[";
        case (w_up) inside
            "K", "R", "G", "Y", "B", "M", "C", "W": begin
                w_code.bytes[2] = "3";
                w_code.bytes[3] = cata_pkg::C_ZERO + {5'd0, fg_digit(w_up)};
                w_code.bytes[4] = "m";
                w_code.len      = 3'd5;
            end
            ["0":"7"]: begin
                w_code.bytes[2] = "4";
                w_code.bytes[3] = w_up;
                w_code.bytes[4] = "m";
                w_code.len      = 3'd5;
            end
            "A": begin
                w_code.bytes[0] = cata_pkg::C_PREFIX;
                w_code.len      = 3'd1;
            end
            "<": begin
                w_code.bytes[0] = cata_pkg::C_BS;
                w_code.len      = 3'd1;
            end
            "[": begin
                w_code.bytes[0] = cata_pkg::C_CR;
                w_code.len      = 3'd1;
            end
            "]": begin
                w_code.bytes[0] = cata_pkg::C_LF;
                w_code.len      = 3'd1;
            end
            ">": begin
                w_code.bytes[2] = "K";
                w_code.len      = 3'd3;
            end
            "L": begin
                w_code.bytes[2] = "2";
                w_code.bytes[3] = "J";
                w_code.len      = 3'd4;
            end
            "-", "_", "N": begin
                w_code.bytes[2] = "0";
                w_code.bytes[3] = "m";
                w_code.len      = 3'd4;
            end
            "H": begin
                w_code.bytes[2] = "1";
                w_code.bytes[3] = "m";
                w_code.len      = 3'd4;
            end
            "I": begin
                w_code.bytes[2] = "5";
                w_code.bytes[3] = "m";
                w_code.len      = 3'd4;
            end
            ".", ",", ";": begin
                w_code.len = 3'd0;
            end
            default: begin
                if (w_raw >= cata_pkg::C_HIGH) begin
                    if (w_cnt >= 8'd100) begin
                        w_code.bytes[2] = "1";
                        w_code.bytes[3] = cata_pkg::C_ZERO + {4'd0, w_tens};
                        w_code.bytes[4] = cata_pkg::C_ZERO + {4'd0, w_ones};
                        w_code.bytes[5] = "C";
                        w_code.len      = 3'd6;
                    end else if (w_cnt >= 8'd10) begin
                        w_code.bytes[2] = cata_pkg::C_ZERO + {4'd0, w_tens};
                        w_code.bytes[3] = cata_pkg::C_ZERO + {4'd0, w_ones};
                        w_code.bytes[4] = "C";
                        w_code.len      = 3'd5;
                    end else begin
                        w_code.bytes[2] = cata_pkg::C_ZERO + {4'd0, w_ones};
                        w_code.bytes[3] = "C";
                        w_code.len      = 3'd4;
                    end
                end else if (w_raw == 8'd0) begin
                    w_code.bytes[0] = cata_pkg::C_PREFIX;
                    w_code.len      = 3'd1;
                end else begin
                    w_code.bytes[0] = cata_pkg::C_PREFIX;
                    w_code.bytes[1] = w_raw;
                    w_code.len      = 3'd2;
                end
            end
        endcase
    end

    // Pick the run for this byte: code translation, prefix swallow or pass-through.
    always_comb begin
        n_prefix = r_prefix;
        w_desc   = '0;
        if (r_prefix) begin
            w_desc = w_code;
        end else if (w_raw != cata_pkg::C_PREFIX) begin
            w_desc.bytes[0] = w_raw;
            w_desc.len      = 3'd1;
        end
        if (w_accept) begin
            n_prefix = !r_prefix && (w_raw == cata_pkg::C_PREFIX);
        end
    end

    assign o_push.valid     = w_accept && (w_desc.len != '0);
    assign o_push.desc      = w_desc;
    assign o_prefix_pending = r_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
        end else begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== hw/rtl/cata_queue.sv =====
// Small run queue between front and back end.
// Depends on cata_pkg.
module cata_queue #(
    parameter int DEPTH = cata_pkg::Q_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cata_pkg::t_push     i_push,
    input  logic                i_pop,
    output cata_pkg::t_desc     o_head,
    output cata_pkg::t_q_stat   o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cata_pkg::t_desc     r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr;
    logic [PTR_W-1:0]    r_rd;
    logic [CNT_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    n_wr;
    logic [PTR_W-1:0]    n_rd;
    logic [CNT_W-1:0]    n_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    assign w_push = i_push.valid && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/cata_back.sv =====
// Back end: walks the head run byte by byte into the output register.
// Depends on cata_pkg and cata_if.
module cata_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cata_pkg::t_desc     i_head,
    input  cata_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    cata_out_if.source          o_out
);

    logic [cata_pkg::LEN_W-1:0] r_idx;
    logic [cata_pkg::LEN_W-1:0] n_idx;
    logic                       r_valid;
    logic                       n_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;
    logic                       w_free;
    logic                       w_emit;
    logic                       w_is_last;

    assign w_free    = !r_valid || o_out.ready;
    assign w_emit    = w_free && !i_q_stat.empty;
    assign w_is_last = (r_idx == i_head.len - 1'b1);
    assign o_pop     = w_emit && w_is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_free) begin
            n_valid = w_emit;
        end
        if (w_emit) begin
            n_idx = w_is_last ? '0 : r_idx + 1'b1;
        end
    end

    // Payload loads whenever a byte is emitted; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_last;

endmodule

// ===== hw/rtl/ctrl_a_code_to_ansi_translator_unit.sv =====
// Ctrl-A markup to ANSI translator, top level.
// Depends on cata_pkg, cata_if, cata_front, cata_queue, cata_back and the assert header.
//
// Usage:
//   i_in  (valid/ready/in_byte): one raw text byte per accepted request.
//   o_out (valid/ready/out_byte/last_of_run): translated bytes, one per
//   request; last_of_run marks the final byte produced for an input byte.
//   Plain bytes pass through; 0x01 arms a prefix and the next byte selects a
//   control code, an ANSI escape, nothing (delay codes), a cursor-right move,
//   or, for other codes, the prefix and the code byte as they are.
// Path: the front classifies a byte in its accept cycle, its run lands in
//   the queue, and the back end then moves it into the output register.
// Throughput: the output register moves one byte per cycle while o_out.ready
//   is high; an input byte expands to 0 to 6 output bytes. Input accepts
//   one byte per cycle while the Q_DEPTH-entry run queue has room; runs of
//   zero bytes never enter the queue.
// Reset: synchronous, active low; clears the prefix flag, empties the queue
//   and drops the output valid.
// Stall: with o_out.ready low the output byte holds, the back end stops
//   walking its run, and i_in.ready falls once the queue fills.
`include "ctrl_a_code_to_ansi_translator_unit_assert.svh"

module ctrl_a_code_to_ansi_translator_unit #(
    parameter int Q_DEPTH = cata_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cata_in_if.sink     i_in,
    cata_out_if.source  o_out
);

    cata_pkg::t_push    w_push;
    cata_pkg::t_desc    w_head;
    cata_pkg::t_q_stat  w_q_stat;
    logic               w_pop;
    logic               w_prefix;

    // Front: classify each byte and build its output run.
    cata_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .i_q_stat         (w_q_stat),
        .o_push           (w_push),
        .o_prefix_pending (w_prefix)
    );

    // Queue: decouple input acceptance from output stalls.
    cata_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back: emit the head run one byte per cycle while the output is ready.
    cata_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // A bare prefix byte arms the flag.
    `CATA_ASSERT_NEXT(a_prefix_arm,
        i_in.valid && i_in.ready && !w_prefix && i_in.in_byte == cata_pkg::C_PREFIX,
        w_prefix, "prefix byte did not arm the flag")
    // The byte after a prefix always disarms it.
    `CATA_ASSERT_NEXT(a_prefix_clear, i_in.valid && i_in.ready && w_prefix,
        !w_prefix, "prefix flag survived its code byte")
    // A full queue must back-pressure the input.
    `CATA_ASSERT_NOW(a_full_stall, w_q_stat.full, !i_in.ready,
        "input ready while run queue full")
    // Output only starts from a queued run.
    `CATA_ASSERT_NOW(a_out_from_queue, $rose(o_out.valid), $past(!w_q_stat.empty),
        "output valid rose with empty queue")

endmodule
